[rtl/ib_velocity_interpolation_macros.svh]
// Assertion helpers for the RTL
`ifndef IB_VELOCITY_INTERPOLATION_MACROS_SVH
`define IB_VELOCITY_INTERPOLATION_MACROS_SVH

// same-cycle implication
`define IBVI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IBVI_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ibvi_pkg.sv]
package ibvi_pkg;

    localparam int FRAC      = 16;
    localparam int ONE       = 1 << FRAC;
    localparam int GRID_MIN  = 4;
    localparam int GRID_MAX  = 64;
    localparam int NODE_MAX  = 4096;
    localparam int ADDR_W    = 12;
    localparam int MAP_DEPTH = 1 << ADDR_W;
    localparam int ARG_W     = 34;
    localparam int ROOT_W    = 17;

    typedef enum logic [1:0] {
        CMD_MAP    = 2'd0,
        CMD_VEL    = 2'd1,
        CMD_INTERP = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_FLUID  = 2'd2,
        CFG_NONE   = 2'd3
    } t_cfg_reg;

    typedef enum logic [3:0] {
        S_IDLE, S_ARG, S_SQRT, S_WGT,
        S_T0, S_T1, S_T2, S_T3, S_T4, S_T5,
        S_DONE
    } t_state;

endpackage

[rtl/ibvi_isqrt.sv]
// Bit-serial integer square root, rounded down, one result bit per cycle.
module ibvi_isqrt
    import ibvi_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [ARG_W-1:0]  i_arg,
    output logic              o_done,
    output logic [ROOT_W-1:0] o_root
);

    logic [ARG_W-1:0]  r_arg;
    logic [ROOT_W+1:0] r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [4:0]        r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [ROOT_W+3:0] n_shift;
    logic [ROOT_W+3:0] n_sub;
    logic              n_ge;

    always_comb begin
        n_shift = {r_rem, r_arg[ARG_W-1 -: 2]};
        n_sub   = {2'b00, r_root, 2'b01};
        n_ge    = n_shift >= n_sub;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 5'd1;
            if (r_cnt == 5'(ROOT_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_arg  <= i_arg;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_arg <= {r_arg[ARG_W-3:0], 2'b00};
            if (n_ge) begin
                r_rem  <= (ROOT_W+2)'(n_shift - n_sub);
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= (ROOT_W+2)'(n_shift);
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

[rtl/ib_velocity_interpolation.sv]
// Velocity interpolation at immersed-boundary markers with the four-point
// square-root kernel. Map writes (tuser 0) and velocity writes (tuser 1) can
// follow back to back. An interpolation (tuser 2) holds the input off after
// its transaction until its result is loaded. Two bit-serial square roots run
// side by side for 17 iterations. Then each of the 16 taps walks the map
// memory and the velocity memory (map read, direct where the index is in
// range, optional wrapped map read, velocity read for a valid id, multiply,
// accumulate). The result is then loaded into the output register. A finished
// result sits in the output register, and a following interpolation waits in
// its done state while that register is still occupied. Map and velocity
// entries hold no defined value until written. tuser 3 is dropped without a
// result.
module ib_velocity_interpolation
    import ibvi_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // [11:0] cell_index, [24:12] fluid_id, [36:25] node_id, [68:37] vel_x,
    // [100:69] vel_y, [122:101] pos_x, [144:123] pos_y
    input  logic [151:0] i_s_tdata,
    // [1:0] cmd
    input  logic [1:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // [31:0] interp_x, [63:32] interp_y
    output logic [63:0]  o_m_tdata,
    // [0] bad_tap
    output logic         o_m_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_addr,
    input  logic [12:0]  i_cfg_data
);

    `include "ib_velocity_interpolation_macros.svh"

    t_state r_state, n_state;

    logic [6:0]  r_cfg_w, r_cfg_h;
    logic [12:0] r_cfg_nf;
    logic [6:0]  wc, hc;
    logic [12:0] nf;
    logic [12:0] area;

    logic [12:0] r_map [MAP_DEPTH];
    logic [63:0] r_vel [NODE_MAX];
    logic [12:0] r_map_q;
    logic [63:0] r_vel_q;

    logic [21:0] r_pos_x, r_pos_y;
    logic        x_done, y_done;
    logic [ROOT_W-1:0] x_root, y_root;
    logic [ARG_W-1:0]  arg_x, arg_y;
    logic        sq_start;

    logic [16:0] r_wx [4];
    logic [16:0] r_wy [4];
    logic [3:0]  r_tap;
    logic signed [7:0] r_x, r_y;
    logic [6:0]  r_xw, r_yw;
    logic [16:0] r_p;
    logic [11:0] wrap_idx;
    logic signed [49:0] r_prod_x, r_prod_y;
    logic signed [53:0] r_acc_x, r_acc_y;
    logic        r_bad;

    logic        r_out_valid;
    logic [63:0] r_out_data;
    logic        r_out_bad;

    logic        s_fire;
    t_cmd        cmd;
    logic [7:0]  tx, ty;
    logic signed [15:0] idx;
    logic        idx_ok;
    logic        id_ok;
    logic        map_re, vel_re;
    logic [11:0] map_raddr, vel_raddr;
    logic        out_load;

    function automatic logic [6:0] wrap_mod(input logic [7:0] a, input logic [6:0] m);
        logic [12:0] v;
        logic [12:0] d;
        v = {5'b0, a};
        for (int k = 5; k >= 0; k--) begin
            d = 13'({6'b0, m} << k);
            if (v >= d) v = v - d;
        end
        return v[6:0];
    endfunction

    function automatic logic [16:0] kern_w(input logic [15:0] r, input logic [16:0] q,
                                           input logic [1:0] k);
        logic signed [19:0] lo, hi, qq, n;
        lo = 20'sd196608 - $signed({3'b0, r, 1'b0});
        hi = 20'sd65536 + $signed({3'b0, r, 1'b0});
        qq = $signed({3'b0, q});
        unique case (k)
            2'd0: n = lo - qq;
            2'd1: n = lo + qq;
            2'd2: n = hi + qq;
            default: n = hi - qq;
        endcase
        return n[19] ? 17'd0 : n[19:3];
    endfunction

    function automatic logic [31:0] sat32(input logic signed [53:0] a);
        logic signed [37:0] s;
        s = 38'(a >>> FRAC);
        if (s > 38'sh007FFFFFFF) return 32'h7FFF_FFFF;
        if (s < -38'sh0080000000) return 32'h8000_0000;
        return s[31:0];
    endfunction

    // clamped configuration
    always_comb begin
        wc = (r_cfg_w < 7'(GRID_MIN)) ? 7'(GRID_MIN) :
             (r_cfg_w > 7'(GRID_MAX)) ? 7'(GRID_MAX) : r_cfg_w;
        hc = (r_cfg_h < 7'(GRID_MIN)) ? 7'(GRID_MIN) :
             (r_cfg_h > 7'(GRID_MAX)) ? 7'(GRID_MAX) : r_cfg_h;
        nf = (r_cfg_nf > 13'(NODE_MAX)) ? 13'(NODE_MAX) : r_cfg_nf;
        area = 13'(wc * hc);
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w  <= 7'd64;
            r_cfg_h  <= 7'd64;
            r_cfg_nf <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                CFG_WIDTH:  r_cfg_w  <= i_cfg_data[6:0];
                CFG_HEIGHT: r_cfg_h  <= i_cfg_data[6:0];
                CFG_FLUID:  r_cfg_nf <= i_cfg_data;
                CFG_NONE:   ;
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign s_fire     = i_s_tvalid && o_s_tready;
    assign cmd        = t_cmd'(i_s_tuser);

    // kernel square-root arguments: one^2 + 4 r (one - r)
    always_comb begin
        logic [16:0] omx, omy;
        omx   = 17'(ONE) - {1'b0, r_pos_x[15:0]};
        omy   = 17'(ONE) - {1'b0, r_pos_y[15:0]};
        arg_x = (ARG_W)'(64'(1) << (2 * FRAC)) +
                {{16'b0, r_pos_x[15:0]} * {15'b0, omx}, 2'b00};
        arg_y = (ARG_W)'(64'(1) << (2 * FRAC)) +
                {{16'b0, r_pos_y[15:0]} * {15'b0, omy}, 2'b00};
    end
    assign sq_start = (r_state == S_ARG);

    ibvi_isqrt u_sqrt_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_arg   (arg_x),
        .o_done  (x_done),
        .o_root  (x_root)
    );

    ibvi_isqrt u_sqrt_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_arg   (arg_y),
        .o_done  (y_done),
        .o_root  (y_root)
    );

    // tap coordinates, corner at floor(pos)-1
    always_comb begin
        tx = 8'({2'b0, r_pos_x[21:16]}) + 8'(r_tap[1:0]) - 8'd1;
        ty = 8'({2'b0, r_pos_y[21:16]}) + 8'(r_tap[3:2]) - 8'd1;
        idx = 16'(r_y) * $signed({9'b0, wc}) + 16'(r_x);
        idx_ok = (idx >= 16'sd0) && (idx < $signed({3'b0, area}));
        id_ok = !r_map_q[12] && (r_map_q < nf);
        wrap_idx = 12'(r_yw * wc + {7'b0, r_xw});
    end

    always_comb begin
        n_state   = r_state;
        map_re    = 1'b0;
        map_raddr = wrap_idx;
        vel_re    = 1'b0;
        vel_raddr = r_map_q[11:0];
        out_load  = 1'b0;
        unique case (r_state)
            S_IDLE: if (s_fire && cmd == CMD_INTERP) n_state = S_ARG;
            S_ARG:  n_state = S_SQRT;
            S_SQRT: if (x_done) n_state = S_WGT;
            S_WGT:  n_state = S_T0;
            S_T0:   n_state = S_T1;
            S_T1: begin
                map_re = 1'b1;
                if (idx_ok) begin
                    map_raddr = idx[11:0];
                    n_state   = S_T2;
                end else begin
                    n_state = S_T3;
                end
            end
            S_T2: begin
                if (id_ok) begin
                    vel_re  = 1'b1;
                    n_state = S_T4;
                end else begin
                    map_re  = 1'b1;
                    n_state = S_T3;
                end
            end
            S_T3: begin
                vel_re  = id_ok;
                n_state = id_ok ? S_T4 : S_T5;
            end
            S_T4: n_state = S_T5;
            S_T5: n_state = (r_tap == 4'd15) ? S_DONE : S_T0;
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (s_fire && cmd == CMD_MAP)
            r_map[i_s_tdata[11:0]] <= i_s_tdata[24:12];
        if (map_re)
            r_map_q <= r_map[map_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (s_fire && cmd == CMD_VEL)
            r_vel[i_s_tdata[36:25]] <= {i_s_tdata[100:69], i_s_tdata[68:37]};
        if (vel_re)
            r_vel_q <= r_vel[vel_raddr];
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (s_fire) begin
                    r_pos_x <= i_s_tdata[122:101];
                    r_pos_y <= i_s_tdata[144:123];
                end
                r_tap   <= '0;
                r_acc_x <= '0;
                r_acc_y <= '0;
                r_bad   <= 1'b0;
            end
            S_WGT: begin
                for (int k = 0; k < 4; k++) begin
                    r_wx[k] <= kern_w(r_pos_x[15:0], x_root, 2'(k));
                    r_wy[k] <= kern_w(r_pos_y[15:0], y_root, 2'(k));
                end
            end
            S_T0: begin
                r_x  <= $signed(tx);
                r_y  <= $signed(ty);
                r_xw <= wrap_mod(tx + {1'b0, wc}, wc);
                r_yw <= wrap_mod(ty + {1'b0, hc}, hc);
                r_p  <= 17'(({17'b0, r_wx[r_tap[1:0]]} * {17'b0, r_wy[r_tap[3:2]]}) >> FRAC);
            end
            S_T3: begin
                if (!id_ok) begin
                    r_bad    <= 1'b1;
                    r_prod_x <= '0;
                    r_prod_y <= '0;
                end
            end
            S_T4: begin
                r_prod_x <= $signed({1'b0, r_p}) * $signed(r_vel_q[31:0]);
                r_prod_y <= $signed({1'b0, r_p}) * $signed(r_vel_q[63:32]);
            end
            S_T5: begin
                r_acc_x <= r_acc_x + 54'(r_prod_x);
                r_acc_y <= r_acc_y + 54'(r_prod_y);
                r_tap   <= r_tap + 4'd1;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= {sat32(r_acc_y), sat32(r_acc_x)};
            r_out_bad  <= r_bad;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_bad;

    `IBVI_ASSERT_NOW(a_sqrt_lockstep, r_state == S_SQRT, x_done == y_done, "sqrt units out of step")
    `IBVI_ASSERT_NXT(a_tap_step, r_state == S_T5 && r_tap != 4'd15, r_state == S_T0 && r_tap == $past(r_tap) + 4'd1, "tap sequence broken")
    `IBVI_ASSERT_NXT(a_out_source, r_state != S_DONE && !r_out_valid, !r_out_valid, "result without finished interpolation")
    `IBVI_ASSERT_NOW(a_vel_read_ok, vel_re, id_ok, "velocity read with invalid id")

endmodule

[sim/ib_velocity_interpolation_test.sv]
module ib_velocity_interpolation_test;
    import ibvi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int DRAIN_CYCLES = 160;

    typedef struct {
        t_cmd               cmd;
        logic [11:0]        cidx;
        logic signed [12:0] fid;
        logic [11:0]        node;
        logic [31:0]        vx;
        logic [31:0]        vy;
        logic [21:0]        px;
        logic [21:0]        py;
    } t_marker_op;

    typedef struct {
        logic [31:0] vx;
        logic [31:0] vy;
        logic        bad;
    } t_interp_res;

    typedef longint t_wvec[4];

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic [151:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tready = 1'b0;
    logic         cfg_valid = 1'b0;
    logic [1:0]   cfg_addr = '0;
    logic [12:0]  cfg_data = '0;
    logic         o_s_tready, o_m_tvalid, o_m_tuser, o_cfg_ready;
    logic [63:0]  o_m_tdata;

    ib_velocity_interpolation DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_addr(cfg_addr), .i_cfg_data(cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // shadow state of the block, updated as transactions are accepted
    logic signed [12:0] cell_ids[MAP_DEPTH];
    logic [31:0]        node_vx[NODE_MAX];
    logic [31:0]        node_vy[NODE_MAX];
    logic [6:0]         width_reg = 7'd64;
    logic [6:0]         height_reg = 7'd64;
    logic [12:0]        nodes_reg = 13'd0;

    t_marker_op  pending_ops[$];
    t_interp_res expected_interp[$];
    t_marker_op  cur_op;
    int          err_cnt = 0;
    int          cycle_cnt = 0;
    bit          quiet = 1'b0;
    int          hold_left = 0;

    // generator-side bookkeeping so no unwritten entry is ever read
    bit          cell_written[MAP_DEPTH];
    int          node_pool[$];
    bit          node_written[NODE_MAX];

    function automatic longint root_floor(longint v);
        longint res, t;
        res = 0;
        for (int b = 20; b >= 0; b--) begin
            t = res | (longint'(1) << b);
            if (t * t <= v) res = t;
        end
        return res;
    endfunction

    function automatic t_wvec kernel_weights(longint r);
        t_wvec  w;
        longint q, n[4];
        q = root_floor((longint'(ONE) << FRAC) + 4 * r * (ONE - r));
        n[0] = 3 * ONE - 2 * r - q;
        n[1] = 3 * ONE - 2 * r + q;
        n[2] = ONE + 2 * r + q;
        n[3] = ONE + 2 * r - q;
        for (int k = 0; k < 4; k++) w[k] = (n[k] < 0) ? 0 : (n[k] >>> 3);
        return w;
    endfunction

    function automatic longint clampl(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic t_interp_res interpolate(logic [21:0] px, logic [21:0] py);
        t_interp_res res;
        t_wvec       wx, wy;
        longint      gw, gh, nf, bx, by, x, y, idx, id, p, sx, sy;
        gw = clampl(longint'(width_reg), GRID_MIN, GRID_MAX);
        gh = clampl(longint'(height_reg), GRID_MIN, GRID_MAX);
        nf = clampl(longint'(nodes_reg), 0, NODE_MAX);
        bx = longint'(px >> FRAC) - 1;
        by = longint'(py >> FRAC) - 1;
        wx = kernel_weights(longint'(px[FRAC-1:0]));
        wy = kernel_weights(longint'(py[FRAC-1:0]));
        sx = 0;
        sy = 0;
        res.bad = 1'b0;
        for (int iy = 0; iy < 4; iy++) begin
            for (int ix = 0; ix < 4; ix++) begin
                x = bx + ix;
                y = by + iy;
                idx = y * gw + x;
                id = -1;
                if (idx >= 0 && idx < gw * gh) id = longint'(cell_ids[idx]);
                if (id < 0 || id >= nf)
                    id = longint'(cell_ids[((y + gh) % gh) * gw + (x + gw) % gw]);
                if (id < 0 || id >= nf) begin
                    res.bad = 1'b1;
                end else begin
                    p = (wx[ix] * wy[iy]) >>> FRAC;
                    sx += p * longint'($signed(node_vx[id]));
                    sy += p * longint'($signed(node_vy[id]));
                end
            end
        end
        res.vx = 32'(clampl(sx >>> FRAC, -64'sd2147483648, 64'sd2147483647));
        res.vy = 32'(clampl(sy >>> FRAC, -64'sd2147483648, 64'sd2147483647));
        return res;
    endfunction

    function automatic void absorb_op(t_marker_op op);
        case (op.cmd)
            CMD_MAP: cell_ids[op.cidx] = op.fid;
            CMD_VEL: begin
                node_vx[op.node] = op.vx;
                node_vy[op.node] = op.vy;
            end
            CMD_INTERP: expected_interp.push_back(interpolate(op.px, op.py));
            default: ;
        endcase
    endfunction

    // driver
    always @(posedge i_clk) begin : drive_input
        t_marker_op nxt;
        if (i_rst_n) begin
            if (s_tvalid && o_s_tready) absorb_op(cur_op);
            if (!s_tvalid || o_s_tready) begin
                if (pending_ops.size() > 0 && (quiet || $urandom_range(99) >= 20)) begin
                    nxt = pending_ops.pop_front();
                    cur_op <= nxt;
                    s_tvalid <= 1'b1;
                    s_tuser <= nxt.cmd;
                    s_tdata <= {7'd0, nxt.py, nxt.px, nxt.vy, nxt.vx, nxt.node,
                                nxt.fid, nxt.cidx};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver hold-off, counted down on its own
    always @(posedge i_clk) begin
        if (hold_left > 0) hold_left <= hold_left - 1;
    end

    // monitor
    always @(posedge i_clk) begin : watch_output
        t_interp_res want;
        if (i_rst_n) begin
            if (o_m_tvalid && m_tready) begin
                if (expected_interp.size() == 0) begin
                    $error("unexpected result transaction x=%h y=%h", o_m_tdata[31:0],
                           o_m_tdata[63:32]);
                    err_cnt++;
                end else begin
                    want = expected_interp.pop_front();
                    if (o_m_tdata[31:0] !== want.vx) begin
                        $error("interp_x expected %h actual %h", want.vx, o_m_tdata[31:0]);
                        err_cnt++;
                    end
                    if (o_m_tdata[63:32] !== want.vy) begin
                        $error("interp_y expected %h actual %h", want.vy, o_m_tdata[63:32]);
                        err_cnt++;
                    end
                    if (o_m_tuser !== want.bad) begin
                        $error("bad_tap expected %b actual %b", want.bad, o_m_tuser);
                        err_cnt++;
                    end
                end
            end
            m_tready <= (hold_left == 0) && (quiet || $urandom_range(99) >= 20);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(t_cfg_reg idx, logic [12:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_WIDTH:  width_reg = val[6:0];
            CFG_HEIGHT: height_reg = val[6:0];
            CFG_FLUID:  nodes_reg = val;
            default: ;
        endcase
    endtask

    task automatic push_op(t_cmd cmd, int cidx, int fid, int node, logic [31:0] vx,
                           logic [31:0] vy, logic [21:0] px, logic [21:0] py);
        t_marker_op op;
        op.cmd = cmd;
        op.cidx = 12'(cidx);
        op.fid = 13'(fid);
        op.node = 12'(node);
        op.vx = vx;
        op.vy = vy;
        op.px = px;
        op.py = py;
        if (cmd == CMD_MAP) cell_written[op.cidx] = 1'b1;
        if (cmd == CMD_VEL && !node_written[op.node]) begin
            node_written[op.node] = 1'b1;
            node_pool.push_back(int'(op.node));
        end
        pending_ops.push_back(op);
    endtask

    function automatic int pick_id();
        if ($urandom_range(99) < 15) return -1;
        return node_pool[$urandom_range(node_pool.size() - 1)];
    endfunction

    function automatic logic [21:0] pick_pos(int extent);
        if ($urandom_range(9) == 0) return 22'($urandom);
        return {6'($urandom_range(extent + 1)), 16'($urandom)};
    endfunction

    task automatic map_cell(int c);
        push_op(CMD_MAP, c, pick_id(), $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    // every cell of the active grid must hold an id before interpolation
    task automatic cover_grid();
        int gw, gh;
        gw = int'(clampl(longint'(width_reg), GRID_MIN, GRID_MAX));
        gh = int'(clampl(longint'(height_reg), GRID_MIN, GRID_MAX));
        for (int c = 0; c < gw * gh; c++)
            if (!cell_written[c]) map_cell(c);
    endtask

    task automatic random_ops(int count);
        int gw, gh, k;
        gw = int'(clampl(longint'(width_reg), GRID_MIN, GRID_MAX));
        gh = int'(clampl(longint'(height_reg), GRID_MIN, GRID_MAX));
        for (int n = 0; n < count; n++) begin
            k = $urandom_range(99);
            if (k < 45)
                push_op(CMD_INTERP, $urandom, $urandom, $urandom, $urandom, $urandom,
                        pick_pos(gw), pick_pos(gh));
            else if (k < 70)
                map_cell($urandom_range(99) < 85 ? $urandom_range(gw * gh - 1)
                                                  : $urandom_range(MAP_DEPTH - 1));
            else if (k < 92)
                push_op(CMD_VEL, $urandom, $urandom, ($urandom_range(1) ?
                        $urandom_range(15) : $urandom_range(NODE_MAX - 1)),
                        $urandom, $urandom, $urandom, $urandom);
            else
                push_op(CMD_NONE, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom);
        end
    endtask

    task automatic drain();
        wait (pending_ops.size() == 0 && !s_tvalid && expected_interp.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(int w, int h, int nf, int count);
        write_reg(CFG_WIDTH, 13'(w));
        write_reg(CFG_HEIGHT, 13'(h));
        write_reg(CFG_FLUID, 13'(nf));
        cover_grid();
        random_ops(count);
        drain();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // a small set of nodes, low ids and both ends of the id range
        push_op(CMD_VEL, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
        push_op(CMD_VEL, 0, 0, 4095, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
        for (int n = 1; n < 8; n++)
            push_op(CMD_VEL, 0, 0, n, $urandom, $urandom, 0, 0);
        for (int n = 0; n < 24; n++)
            push_op(CMD_VEL, 0, 0, $urandom_range(NODE_MAX - 1), $urandom, $urandom, 0, 0);
        drain();

        // directed: small grid with the full fluid count
        write_reg(CFG_WIDTH, 13'd4);
        write_reg(CFG_HEIGHT, 13'd4);
        write_reg(CFG_FLUID, 13'd4096);
        push_op(CMD_MAP, 0, -1, 0, 0, 0, 0, 0);
        push_op(CMD_MAP, 1, 4095, 0, 0, 0, 0, 0);
        cover_grid();
        push_op(CMD_MAP, 4095, 0, 0, 0, 0, 0, 0);
        push_op(CMD_INTERP, 0, 0, 0, 0, 0, 22'h0, 22'h0);
        push_op(CMD_INTERP, 0, 0, 0, 0, 0, 22'h0_FFFF, 22'h1_0000);
        push_op(CMD_INTERP, 0, 0, 0, 0, 0, 22'h3F_FFFF, 22'h3F_FFFF);
        push_op(CMD_INTERP, 0, 0, 0, 0, 0, 22'h2_8000, 22'h0_0001);
        push_op(CMD_INTERP, 0, 0, 0, 0, 0, 22'h3_0000, 22'h5_C000);
        push_op(CMD_NONE, 4095, -1, 4095, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 22'h3F_FFFF,
                22'h3F_FFFF);
        push_op(CMD_INTERP, 0, 0, 0, 0, 0, 22'h1_8000, 22'h1_8000);
        drain();

        // a width below the minimum acts as the minimum, few valid ids
        run_phase(0, 5, 3, 250);

        // wide and flat, fluid count clamped; receiver stalls a long while
        hold_left = 700;
        run_phase(64, 4, 8191, 250);

        quiet = 1'b1;
        run_phase(4, 64, 100, 250);
        quiet = 1'b0;

        // no valid ids at all
        run_phase(23, 11, 0, 200);

        // width clamped to the maximum, height to the minimum
        run_phase(127, 2, 4096, 120);

        run_phase(9, 7, 2000, 180);

        if (err_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
